// ===== hdl/rlbc_pkg.sv =====
// shared constants and widths for the run-limited binary sequence counter
`timescale 1ns / 1ps
`default_nettype none
package rlbc_pkg;
	localparam int CNT_W = 8;
	localparam int VAL_W = 30;
	localparam logic [31:0] PRIME = 32'd1000000007;
	localparam logic [31:0] PRIME_X2 = 32'd2000000014;
endpackage
`default_nettype wire

// ===== hdl/rlbc_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface rlbc_req_if;
	logic valid;
	logic ready;
	logic [rlbc_pkg::CNT_W-1:0] zero_count;
	logic [rlbc_pkg::CNT_W-1:0] one_count;
	logic [rlbc_pkg::CNT_W-1:0] run_limit;
	modport source (output valid, output zero_count, output one_count, output run_limit,
		input ready);
	modport sink (input valid, input zero_count, input one_count, input run_limit,
		output ready);
endinterface

interface rlbc_res_if;
	logic valid;
	logic ready;
	logic [rlbc_pkg::VAL_W-1:0] stable_count;
	modport source (output valid, output stable_count, input ready);
	modport sink (input valid, input stable_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/run_limited_binary_count.sv =====
// run-limited binary sequence counter: table fill through one shared modular adder
// interior table cells take two reads from the table memories (upper neighbour, then the
//   run-limit offsets), then two passes through the shared modular adder; border cells are
//   written directly
// throughput: one request at a time, next request taken once the block is back in idle
// reset: arst_n clears sequencer and output valid; table memories are not cleared
`timescale 1ns / 1ps
`default_nettype none
module run_limited_binary_count #(
	parameter int MAX_COUNT = 255
) (
	input wire logic clk,
	input wire logic arst_n,
	rlbc_req_if.sink req,
	rlbc_res_if.source result
);
	localparam int ROW = MAX_COUNT + 1;
	localparam int DEPTH = ROW * ROW;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam int LW = (CW > rlbc_pkg::CNT_W) ? CW : rlbc_pkg::CNT_W;
	localparam int VW = rlbc_pkg::VAL_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CELL  = 3'd1;
	localparam logic [2:0] ST_RDS   = 3'd2;
	localparam logic [2:0] ST_CALCZ = 3'd3;
	localparam logic [2:0] ST_CALCO = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [CW-1:0] zeros_q, ones_q, i_q, j_q;
	logic [rlbc_pkg::CNT_W-1:0] lim_q;
	logic [AW-1:0] row_base_q, lim_row_q, lim_col_q;
	logic [VW-1:0] zu_q, ou_q, zl_q, ol_q, z_new_q;
	logic [VW-1:0] rd_z_q, rd_o_q;
	logic [VW-1:0] out_q;
	logic out_valid_q;

	logic [VW-1:0] zmem [DEPTH];
	logic [VW-1:0] omem [DEPTH];

	// request clamp and offsets
	logic [CW-1:0] zeros_clamp, ones_clamp;
	logic [31:0] lim_row_full;
	always_comb begin
		zeros_clamp = (32'(req.zero_count) > 32'(MAX_COUNT)) ? CW'(MAX_COUNT)
			: CW'(req.zero_count);
		ones_clamp = (32'(req.one_count) > 32'(MAX_COUNT)) ? CW'(MAX_COUNT)
			: CW'(req.one_count);
		lim_row_full = (32'(req.run_limit) + 32'd1) * 32'(ROW);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.stable_count = out_q;

	// cell position and addresses
	logic [AW-1:0] idx, up_addr;
	logic interior, last_col, last_row, i_gt_lim, j_gt_lim;
	logic z_edge, o_edge;
	always_comb begin
		idx = row_base_q + AW'(j_q);
		up_addr = idx - AW'(ROW);
		interior = (i_q != '0) && (j_q != '0);
		last_col = (j_q == ones_q);
		last_row = (i_q == zeros_q);
		i_gt_lim = LW'(i_q) > LW'(lim_q);
		j_gt_lim = LW'(j_q) > LW'(lim_q);
		z_edge = (j_q == '0) && (i_q != '0) && !i_gt_lim;
		o_edge = (i_q == '0) && (j_q != '0) && !j_gt_lim;
	end

	// shared modular adder: (a + b - c) mod prime
	logic [VW-1:0] ua, ub, uc, usum;
	logic [31:0] ut;
	always_comb begin
		case (state_q)
			ST_CALCZ: begin
				ua = zu_q;
				ub = ou_q;
				uc = i_gt_lim ? rd_o_q : '0;
			end
			ST_CALCO: begin
				ua = zl_q;
				ub = ol_q;
				uc = j_gt_lim ? rd_z_q : '0;
			end
			default: begin
				ua = zl_q;
				ub = ol_q;
				uc = '0;
			end
		endcase
		ut = 32'(ua) + 32'(ub) + rlbc_pkg::PRIME - 32'(uc);
		if (ut >= rlbc_pkg::PRIME_X2) begin
			ut = ut - rlbc_pkg::PRIME_X2;
		end else if (ut >= rlbc_pkg::PRIME) begin
			ut = ut - rlbc_pkg::PRIME;
		end
		usum = ut[VW-1:0];
	end

	// memory read and write control
	logic rd_en, wr_en;
	logic [AW-1:0] rz_addr, ro_addr;
	logic [VW-1:0] wz_data, wo_data;
	always_comb begin
		rd_en = 1'b0;
		rz_addr = up_addr;
		ro_addr = up_addr;
		wr_en = 1'b0;
		wz_data = z_new_q;
		wo_data = usum;
		case (state_q)
			ST_CELL: begin
				if (interior) begin
					rd_en = 1'b1;
				end else begin
					wr_en = 1'b1;
					wz_data = VW'(z_edge);
					wo_data = VW'(o_edge);
				end
			end
			ST_RDS: begin
				rd_en = 1'b1;
				rz_addr = idx - lim_col_q;
				ro_addr = idx - lim_row_q;
			end
			ST_CALCO: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// table memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			zmem[idx] <= wz_data;
			omem[idx] <= wo_data;
		end
		if (rd_en) begin
			rd_z_q <= zmem[rz_addr];
			rd_o_q <= omem[ro_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			zeros_q <= zeros_clamp;
			ones_q <= ones_clamp;
			lim_q <= req.run_limit;
			lim_row_q <= lim_row_full[AW-1:0];
			lim_col_q <= AW'(32'(req.run_limit) + 32'd1);
		end
		if (state_q == ST_RDS) begin
			zu_q <= rd_z_q;
			ou_q <= rd_o_q;
		end
		if (state_q == ST_CALCZ) begin
			z_new_q <= usum;
		end
		if (wr_en) begin
			zl_q <= wz_data;
			ol_q <= wo_data;
		end
	end

	// sequencer
	logic res_load;
	assign res_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			row_base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// cell walk in row-major order
			if (wr_en) begin
				if (last_col) begin
					if (last_row) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CELL;
						i_q <= i_q + 1'b1;
						j_q <= '0;
						row_base_q <= row_base_q + AW'(ROW);
					end
				end else begin
					state_q <= ST_CELL;
					j_q <= j_q + 1'b1;
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (req.valid) begin
							state_q <= ST_CELL;
							i_q <= '0;
							j_q <= '0;
							row_base_q <= '0;
						end
					end
					ST_CELL: state_q <= ST_RDS;
					ST_RDS: state_q <= ST_CALCZ;
					ST_CALCZ: state_q <= ST_CALCO;
					ST_DONE: begin
						if (res_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= ((zeros_q == '0) && (ones_q == '0)) ? VW'(1) : usum;
		end
	end
endmodule
`default_nettype wire
